// File: sv/mf7_pkg.sv
// Shared widths, codes and types of the 7x7 box mean filter.
`timescale 1ns / 1ps

package mf7_pkg;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int ROW_W   = 12;
    localparam int OCOL_W  = 10;
    localparam int IW_W    = 11;
    localparam int IH_W    = 12;
    localparam int CFG_W   = 12;
    localparam int SUM_W   = 11;
    localparam int TOT_W   = 14;
    localparam int HIST_W  = 48;
    localparam int OUT_W   = 32;

    // Window geometry
    localparam int WIN_TAPS  = 7;
    localparam int HALF_WIN  = 3;
    localparam int FULL_SPAN = 6;

    // floor(x/49) == (x * 21400) >> 20 for every x below 43690
    localparam int RECIP_W    = 15;
    localparam int MEAN_SHIFT = 20;
    localparam logic [RECIP_W-1:0] MEAN_RECIP = 15'd21400;

    // Register indexes
    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    // One result item
    typedef struct packed {
        logic              frame_last;
        logic [OCOL_W-1:0] out_col;
        logic [ROW_W-1:0]  out_row;
        logic [PIX_W-1:0]  mean_value;
    } res_t;

endpackage

// File: sv/mf7_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module mf7_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/mean_filter_7x7_stream.sv
// 7x7 box mean filter over a raster pixel stream, line buffer in RAM.
// Pipeline: a result passes stage 1, stage 2 and the output register before m_tvalid.
// Throughput: 1 pixel per cycle while the skid is empty; the line buffer does one read
//   and one write per pixel, forwarding the previous pixel's write on a same-column hit.
// Reset: counters, column sums and window total clear; width and height go to 512;
//   line buffer contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module mean_filter_7x7_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // slave side
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mf7_pkg::PIX_W-1:0]    s_tdata,    // [7:0] pixel_value
    input  logic [0:0]                   s_tuser,    // [0] frame_start
    // master side
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mf7_pkg::OUT_W-1:0]    m_tdata,    // [7:0] mean_value, [19:8] out_row,
                                                     // [29:20] out_col, [31:30] zero
    output logic                         m_tlast,    // frame_last
    // configuration
    input  logic                         cfg_we,
    input  logic [0:0]                   cfg_index,
    input  logic [mf7_pkg::CFG_W-1:0]    cfg_data
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W = (COL_W > mf7_pkg::IW_W) ? COL_W : mf7_pkg::IW_W;
    localparam int IW_MAX = (1 << mf7_pkg::IW_W) - 1;
    localparam int W_CAP = (MAX_WIDTH > IW_MAX) ? IW_MAX : MAX_WIDTH;

    // configuration registers
    logic [mf7_pkg::IW_W-1:0] img_w_reg;
    logic [mf7_pkg::IH_W-1:0] img_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= mf7_pkg::IW_W'(512);
            img_h_reg <= mf7_pkg::IH_W'(512);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mf7_pkg::REG_IMAGE_WIDTH:  img_w_reg <= cfg_data[mf7_pkg::IW_W-1:0];
                mf7_pkg::REG_IMAGE_HEIGHT: img_h_reg <= cfg_data[mf7_pkg::IH_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size
    logic [mf7_pkg::IW_W-1:0] eff_w;
    logic [mf7_pkg::IH_W-1:0] eff_h;
    logic [CMP_W-1:0]         w_cmp;

    always_comb
    begin
        if (img_w_reg == '0)
            eff_w = mf7_pkg::IW_W'(1);
        else if (img_w_reg > mf7_pkg::IW_W'(W_CAP))
            eff_w = mf7_pkg::IW_W'(W_CAP);
        else
            eff_w = img_w_reg;
        eff_h = (img_h_reg == '0) ? mf7_pkg::IH_W'(1) : img_h_reg;
        w_cmp = CMP_W'(eff_w);
    end

    // pipeline control
    logic adv;
    logic in_fire;

    logic                       out_valid_reg;
    logic                       skid_valid_reg;
    mf7_pkg::res_t              out_reg;
    mf7_pkg::res_t              skid_reg;

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign in_fire  = s_tvalid && adv;

    // position counters
    logic [mf7_pkg::ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0]          col_reg, col_next;

    logic [CMP_W-1:0]          c_a, c_b, c0, c_inc;
    logic [mf7_pkg::ROW_W-1:0] r_a, r_b, r0, r_inc;
    logic                      emit0;
    logic                      last0;
    logic [mf7_pkg::ROW_W-1:0] orow0;
    logic [mf7_pkg::OCOL_W-1:0] ocol0;

    // stage 0: place the incoming pixel, work out the counters after it
    always_comb
    begin
        c_a = s_tuser[0] ? '0 : CMP_W'(col_reg);
        r_a = s_tuser[0] ? '0 : row_reg;
        if (c_a >= w_cmp)
        begin
            c_b = '0;
            r_b = r_a + mf7_pkg::ROW_W'(1);
        end
        else
        begin
            c_b = c_a;
            r_b = r_a;
        end
        r0 = (r_b >= eff_h) ? '0 : r_b;
        c0 = c_b;

        c_inc = c0 + CMP_W'(1);
        r_inc = r0 + mf7_pkg::ROW_W'(1);
        if (c_inc >= w_cmp)
        begin
            col_next = '0;
            row_next = (r_inc >= eff_h) ? '0 : r_inc;
        end
        else
        begin
            col_next = c_inc[COL_W-1:0];
            row_next = r0;
        end

        emit0 = (r0 >= mf7_pkg::ROW_W'(mf7_pkg::FULL_SPAN))
             && (c0 >= CMP_W'(mf7_pkg::FULL_SPAN));
        last0 = (r0 == eff_h - mf7_pkg::IH_W'(1)) && (c0 == w_cmp - CMP_W'(1));
        orow0 = r0 - mf7_pkg::ROW_W'(mf7_pkg::HALF_WIN);
        ocol0 = mf7_pkg::OCOL_W'(c0 - CMP_W'(mf7_pkg::HALF_WIN));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (in_fire)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // stage 1 registers
    logic                        s1_valid_reg;
    logic                        s1_emit_reg;
    logic                        s1_last_reg;
    logic                        s1_fwd_reg;
    logic [mf7_pkg::PIX_W-1:0]   s1_pix_reg;
    logic [COL_W-1:0]            s1_col_reg;
    logic [mf7_pkg::ROW_W-1:0]   s1_orow_reg;
    logic [mf7_pkg::OCOL_W-1:0]  s1_ocol_reg;
    logic                        fwd0;

    // same column as the write going out on this edge: old data comes back from RAM
    assign fwd0 = s1_valid_reg && (s1_col_reg == c0[COL_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_fire;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_emit_reg <= emit0;
            s1_last_reg <= last0;
            s1_fwd_reg  <= fwd0;
            s1_pix_reg  <= s_tdata;
            s1_col_reg  <= c0[COL_W-1:0];
            s1_orow_reg <= orow0;
            s1_ocol_reg <= ocol0;
        end
    end

    // line buffer: six previous pixels of each column
    logic                         ram_we;
    logic [mf7_pkg::HIST_W-1:0]   ram_rdata;
    logic [mf7_pkg::HIST_W-1:0]   hist1;
    logic [mf7_pkg::HIST_W-1:0]   hist_new;
    logic [mf7_pkg::HIST_W-1:0]   hist_wr_reg;
    logic [mf7_pkg::SUM_W-1:0]    colsum;

    assign ram_we = adv && s1_valid_reg;

    mf7_ram #(
        .WIDTH (mf7_pkg::HIST_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_col_reg),
        .wdata (hist_new),
        .re    (in_fire),
        .raddr (c0[COL_W-1:0]),
        .rdata (ram_rdata)
    );

    // stage 1: column sum and history update
    always_comb
    begin
        hist1    = s1_fwd_reg ? hist_wr_reg : ram_rdata;
        hist_new = {hist1[mf7_pkg::HIST_W-mf7_pkg::PIX_W-1:0], s1_pix_reg};
        colsum   = mf7_pkg::SUM_W'(s1_pix_reg);
        for (int k = 0; k < mf7_pkg::FULL_SPAN; k++)
        begin
            colsum = colsum + mf7_pkg::SUM_W'(hist1[k*mf7_pkg::PIX_W +: mf7_pkg::PIX_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
            hist_wr_reg <= hist_new;
    end

    // sliding window: seven column sums and their running total
    logic [mf7_pkg::SUM_W-1:0] cs_reg [mf7_pkg::WIN_TAPS];
    logic [mf7_pkg::TOT_W-1:0] total_reg, total_next;

    assign total_next = total_reg + mf7_pkg::TOT_W'(colsum) - mf7_pkg::TOT_W'(cs_reg[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < mf7_pkg::WIN_TAPS; k++)
                cs_reg[k] <= '0;
            total_reg <= '0;
        end
        else if (ram_we)
        begin
            for (int k = 0; k < mf7_pkg::WIN_TAPS - 1; k++)
                cs_reg[k] <= cs_reg[k+1];
            cs_reg[mf7_pkg::WIN_TAPS-1] <= colsum;
            total_reg <= total_next;
        end
    end

    // stage 2 registers
    logic                        s2_valid_reg;
    logic                        s2_last_reg;
    logic [mf7_pkg::ROW_W-1:0]   s2_orow_reg;
    logic [mf7_pkg::OCOL_W-1:0]  s2_ocol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            s2_last_reg <= s1_last_reg;
            s2_orow_reg <= s1_orow_reg;
            s2_ocol_reg <= s1_ocol_reg;
        end
    end

    // stage 2: divide by 49 through the reciprocal
    localparam int PROD_W = mf7_pkg::TOT_W + mf7_pkg::RECIP_W;
    logic [PROD_W-1:0] prod;
    mf7_pkg::res_t     res2;

    assign prod = PROD_W'(total_reg) * PROD_W'(mf7_pkg::MEAN_RECIP);

    always_comb
    begin
        res2.mean_value = prod[mf7_pkg::MEAN_SHIFT +: mf7_pkg::PIX_W];
        res2.out_row    = s2_orow_reg;
        res2.out_col    = s2_ocol_reg;
        res2.frame_last = s2_last_reg;
    end

    // output register with skid stage
    logic push;
    logic pop;

    assign push = adv && s2_valid_reg;
    assign pop  = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_reg <= res2;
            else
                out_reg <= res2;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.out_col, out_reg.out_row, out_reg.mean_value};
    assign m_tlast  = out_reg.frame_last;

endmodule

// File: sv/mf7_chk.sv
// Port-level checker for the 7x7 box mean filter, bound to the top level.
`timescale 1ns / 1ps

module mf7_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [mf7_pkg::OUT_W-1:0]    m_tdata,
    input logic                         m_tlast
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // input side only backs off when a result is waiting
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no result pending");

    // out_row at least 3: no result in the top border rows
    a_row_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[19:8] >= 12'd3)
        else $error("out_row in the border");

endmodule

bind mean_filter_7x7_stream mf7_chk u_mf7_chk (.*);

// File: tb/mf7_checker.sv
// Checker for the 7x7 box mean filter: tracks geometry, predicts each mean and compares.
`timescale 1ns / 1ps

module mf7_checker
    import mf7_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [PIX_W-1:0]  s_tdata,
    input  logic [0:0]        s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,
    input  logic              m_tlast,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output int                mismatches,
    output int                pending,
    output int                checked,
    output int                frame_ends
);

    localparam int MAX_HEIGHT = 4095;
    localparam int PAD_LSB    = PIX_W + ROW_W + OCOL_W;

    // Shadow of the filter: six rows per column, column sum taps, geometry, position
    logic [HIST_W-1:0] line_hist [MAX_WIDTH];
    logic [SUM_W-1:0]  col_sums [WIN_TAPS];
    logic [IW_W-1:0]   width_reg;
    logic [IH_W-1:0]   height_reg;
    int unsigned       row_pos;
    int unsigned       col_pos;
    res_t              mean_q [$];
    int                err_cnt;
    int                ok_cnt;
    int                last_cnt;

    function automatic int unsigned clamp(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    // One pixel through the window; queues the mean it completes, if any
    task automatic take_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned       w;
        int unsigned       h;
        int unsigned       r;
        int unsigned       c;
        logic [SUM_W-1:0]  colsum;
        logic [TOT_W-1:0]  total;
        logic [HIST_W-1:0] hist;
        res_t              item;
        w = clamp(width_reg, MAX_WIDTH);
        h = clamp(height_reg, MAX_HEIGHT);
        if (fs)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        // geometry may have shrunk under the counters
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        r = row_pos;
        c = col_pos;

        hist   = line_hist[c];
        colsum = pix;
        for (int k = 0; k < FULL_SPAN; k++)
            colsum += hist[8*k +: 8];
        line_hist[c] = {hist[HIST_W-9:0], pix};

        for (int k = 0; k < WIN_TAPS - 1; k++)
            col_sums[k] = col_sums[k+1];
        col_sums[WIN_TAPS-1] = colsum;
        total = '0;
        for (int k = 0; k < WIN_TAPS; k++)
            total += col_sums[k];

        if (r >= FULL_SPAN && c >= FULL_SPAN)
        begin
            item.mean_value = total / (WIN_TAPS * WIN_TAPS);
            item.out_row    = r - HALF_WIN;
            item.out_col    = c - HALF_WIN;
            item.frame_last = (r == h - 1) && (c == w - 1);
            mean_q.push_back(item);
        end

        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
                line_hist[i] = '0;
            for (int k = 0; k < WIN_TAPS; k++)
                col_sums[k] = '0;
            width_reg  = 11'd512;
            height_reg = 12'd512;
            row_pos    = 0;
            col_pos    = 0;
            mean_q.delete();
            err_cnt    = 0;
            ok_cnt     = 0;
            last_cnt   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  = cfg_data[IW_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg = cfg_data[IH_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_pixel(s_tdata, s_tuser[0]);
            // result transaction against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (mean_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: result with nothing expected, expected none, actual %h/%b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = mean_q.pop_front();
                    check_field("mean_value", want.mean_value, m_tdata[PIX_W-1:0]);
                    check_field("out_row", want.out_row, m_tdata[PIX_W +: ROW_W]);
                    check_field("out_col", want.out_col, m_tdata[PIX_W+ROW_W +: OCOL_W]);
                    check_field("tdata padding", 0, m_tdata[OUT_W-1:PAD_LSB]);
                    check_field("frame_last", want.frame_last, m_tlast);
                    ok_cnt++;
                    if (want.frame_last)
                        last_cnt++;
                end
            end
        end
        mismatches <= err_cnt;
        pending    <= mean_q.size();
        checked    <= ok_cnt;
        frame_ends <= last_cnt;
    end

endmodule

// File: tb/testbench.sv
// Top of the 7x7 box mean filter regression: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import mf7_pkg::*;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4095;
    localparam int HALF_PERIOD  = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1550;
    localparam int IDLE_PCT     = 35;

    typedef enum int {PIX_RANDOM, PIX_WHITE, PIX_BLACK, PIX_BRIGHT, PIX_DARK} pix_mode_e;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [PIX_W-1:0]  s_tdata   = '0;
    logic [0:0]        s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;
    logic              cfg_we    = 1'b0;
    logic [0:0]        cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              steady    = 1'b0;

    int                mismatches;
    int                pending;
    int                checked;
    int                frame_ends;
    int                pixel_cnt   = 0;
    int                setting_cnt = 0;
    int unsigned       cur_w       = 512;
    int unsigned       cur_h       = 512;

    always #HALF_PERIOD clk = ~clk;

    // receiver stalls at random unless a no-idle stretch is running
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    mean_filter_7x7_stream #(.MAX_WIDTH(MAX_WIDTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mf7_checker #(.MAX_WIDTH(MAX_WIDTH)) mean_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked),
        .frame_ends (frame_ends)
    );

    function automatic int unsigned clamp(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input pix_mode_e mode);
        case (mode)
            PIX_WHITE:  return 8'hFF;
            PIX_BLACK:  return 8'h00;
            PIX_BRIGHT: return $urandom_range(200, 255);
            PIX_DARK:   return $urandom_range(0, 55);
            default:    return $urandom_range(0, 255);
        endcase
    endfunction

    // width data: mostly small rows, some wide, some too narrow; bit 11 is don't-care
    function automatic logic [CFG_W-1:0] pick_width();
        int unsigned      r;
        logic [CFG_W-1:0] d;
        r = $urandom_range(99);
        if (r < 10)
            d = $urandom_range(0, 6);
        else if (r < 25)
            d = $urandom_range(25, 64);
        else
            d = $urandom_range(7, 24);
        d[CFG_W-1] = $urandom_range(1);
        return d;
    endfunction

    function automatic logic [CFG_W-1:0] pick_height();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return $urandom_range(0, 6);
        else if (r < 22)
            return $urandom_range(13, MAX_HEIGHT);
        return $urandom_range(7, 14);
    endfunction

    // one pixel transaction, with random sender gaps
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= fs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixel_cnt++;
    endtask

    // a run of pixels; noisy runs restart the frame now and then
    task automatic send_run(input int unsigned n, input pix_mode_e mode, input logic fs_first,
                            input logic noisy);
        for (int unsigned i = 0; i < n; i++)
            send_pixel(pick_pixel(mode),
                       (i == 0 && fs_first) || (noisy && $urandom_range(99) == 0));
    endtask

    // hold the stream until every predicted mean has come out, then the pipe drains
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_IMAGE_WIDTH)
            cur_w = clamp(val[IW_W-1:0], MAX_WIDTH);
        else
            cur_h = clamp(val[IH_W-1:0], MAX_HEIGHT);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                                input logic width_first);
        if (width_first)
        begin
            write_reg(REG_IMAGE_WIDTH, w_val);
            write_reg(REG_IMAGE_HEIGHT, h_val);
        end
        else
        begin
            write_reg(REG_IMAGE_HEIGHT, h_val);
            write_reg(REG_IMAGE_WIDTH, w_val);
        end
        cfg_we <= 1'b0;
        setting_cnt++;
    endtask

    initial
    begin
        int unsigned rand_items;
        int unsigned nframes;
        int unsigned full;
        int unsigned len;
        int unsigned split;
        int unsigned r;
        logic        prev_whole;
        logic        whole;
        logic        fs;
        logic        noisy;
        pix_mode_e   mode;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry, 512 x 512: seven rows give the first row of means
        send_run(7 * 512 + 20, PIX_RANDOM, 1'b1, 1'b0);
        wait_idle();

        // smallest frame: all white, all black through wraparound, then a restart
        set_geometry(12'd7, 12'd7, 1'b1);
        send_run(49, PIX_WHITE, 1'b1, 1'b0);
        send_run(49, PIX_BLACK, 1'b0, 1'b0);
        send_run(20, PIX_RANDOM, 1'b0, 1'b0);
        send_run(49, PIX_RANDOM, 1'b1, 1'b0);
        wait_idle();

        // widest line: all-ones width clamps to the line buffer size; no idling here
        steady <= 1'b1;
        set_geometry(12'hFFF, 12'd7, 1'b0);
        send_run(MAX_WIDTH * 7, PIX_RANDOM, 1'b1, 1'b0);
        wait_idle();
        steady <= 1'b0;

        // degenerate geometry gives no means at all
        set_geometry(12'd0, 12'hFFF, 1'b1);
        send_run(30, PIX_RANDOM, 1'b1, 1'b0);
        wait_idle();
        set_geometry(12'd6, 12'd0, 1'b0);
        send_run(30, PIX_BRIGHT, 1'b1, 1'b0);
        wait_idle();

        // shrink in mid-frame: column past the new width, then row past the new height
        set_geometry(12'd12, 12'd12, 1'b1);
        send_run(8 * 12 + 10, PIX_RANDOM, 1'b1, 1'b0);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 12'd8);
        cfg_we <= 1'b0;
        send_run(8, PIX_DARK, 1'b0, 1'b0);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 12'd9);
        cfg_we <= 1'b0;
        send_run(9 * 8, PIX_RANDOM, 1'b0, 1'b0);

        // random geometry phases; each opens with a frame start so growth stays safe
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            wait_idle();
            set_geometry(pick_width(), pick_height(), $urandom_range(1));
            nframes    = $urandom_range(1, 3);
            prev_whole = 1'b0;
            for (int f = 0; f < nframes; f++)
            begin
                r     = $urandom_range(9);
                mode  = (r < 6) ? PIX_RANDOM : pix_mode_e'(r - 5);
                full  = cur_w * cur_h;
                if (cur_h > 14 || full > 700)
                    len = cur_w * $urandom_range(7, 10);
                else if ($urandom_range(99) < 15)
                    len = $urandom_range(1, full);
                else
                    len = full;
                whole = (len == full);
                fs    = !prev_whole || $urandom_range(1);
                noisy = ($urandom_range(99) < 10);
                if (f == 0 && len > 2 * cur_w && $urandom_range(99) < 15)
                begin
                    // pause in mid-frame and shrink the width, maybe change the height
                    split = $urandom_range(cur_w, len - 1);
                    send_run(split, mode, 1'b1, noisy);
                    wait_idle();
                    write_reg(REG_IMAGE_WIDTH, $urandom_range(0, cur_w));
                    if ($urandom_range(1))
                        write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, MAX_HEIGHT));
                    cfg_we <= 1'b0;
                    send_run(len - split, mode, 1'b0, noisy);
                    whole = 1'b0;
                end
                else
                    send_run(len, mode, fs, noisy);
                rand_items += len;
                prev_whole  = whole;
            end
        end

        wait_idle();
        $display("Drove %0d pixel transactions over %0d geometry settings, including", pixel_cnt,
                 setting_cnt);
        $display("mid-frame shrinks and restarts; %0d means checked, %0d of them frame ends.",
                 checked, frame_ends);
        if (mismatches == 0 && pending == 0)
            $display("mean_filter_7x7_stream regression: pass");
        else
            $display("mean_filter_7x7_stream regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("Watchdog expired with %0d means still outstanding", pending);
        $display("mean_filter_7x7_stream regression: fail");
        $finish;
    end

endmodule
